// ===== hdl/c2dv_pkg.sv =====
// Shared types and constants for the 2D valid-window convolution block.
package c2dv_pkg;

  localparam int PIX_W       = 8;
  localparam int TAP_W       = 10;
  localparam int WIDTH_W     = 7;
  localparam int HEIGHT_W    = 11;
  localparam int ROW_W       = 10;
  localparam int TAPS_LOW_W  = 60;
  localparam int TAPS_HIGH_W = 30;
  localparam int CONV_W      = 16;
  localparam int MAX_HEIGHT  = 1024;

  // Config bus geometry: 64-bit registers at byte address 8*i.
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;

  // Line buffer slot select; at most two line buffers.
  localparam int SLOT_W      = 1;

  // Products, sum and reciprocal divide.
  localparam int PROD_W      = PIX_W + TAP_W;
  localparam int SUM_W       = 22;
  localparam int DIV_SHIFT   = 26;
  localparam int RECIP_W     = 24;
  localparam int QMAG_W      = SUM_W + RECIP_W - DIV_SHIFT;
  localparam int CONV_POS_MAX = 32767;
  localparam int CONV_NEG_MAX = 32768;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TAPS_LOW     = 2'd2,
    REG_TAPS_HIGH    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_rot;
  } lb_ctrl_t;

endpackage

// ===== hdl/conv2d_valid_window.sv =====
// Top level of the 3x3 valid-window convolution over a raster pixel stream.
//
//   channel  direction  handshake             payload
//   in_      request in in_valid / in_stall   in_pixel, in_plane_start
//   out_     result out out_valid / out_stall out_conv_value, out_last_of_plane
//   cfg      APB r/w    psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One pixel per cycle, sustained while no output stall backs up the pipeline; the
// line buffer memories take one read and one write per pixel at the same column
// address, which sets that rate. A result reaches the output register through
// line buffer read, tap products, sum, and divide and saturate, each registered.
// Reset (synchronous, rst_n low) restores the registers to their defaults and
// clears position, window and pipeline; the line buffers are not cleared.
// A stalled result holds the output register; stages behind it close their gaps
// and intake stops only when every stage holds a request.
module conv2d_valid_window
  import c2dv_pkg::*;
#(
  parameter int MAX_WIDTH   = 64,
  parameter int KERNEL_SIZE = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel requests
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [PIX_W-1:0]             in_pixel,
  input  logic                         in_plane_start,
  // window results
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [CONV_W-1:0]     out_conv_value,
  output logic                         out_last_of_plane,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready
);

  localparam int SLOTS   = KERNEL_SIZE - 1;
  localparam int NT      = KERNEL_SIZE * KERNEL_SIZE;
  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WEW     = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;
  localparam int DIVISOR = 2 * NT;
  localparam longint RECIP = ((64'd1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WIDTH_W-1:0]     width_r;
  logic [HEIGHT_W-1:0]    height_r;
  logic [TAPS_LOW_W-1:0]  taps_low_r;
  logic [TAPS_HIGH_W-1:0] taps_high_r;
  logic                   cfg_wr;
  cfg_idx_t               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_idx_t'(paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_W'(28);
      height_r    <= HEIGHT_W'(28);
      taps_low_r  <= '0;
      taps_high_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  width_r     <= pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r    <= pwdata[HEIGHT_W-1:0];
        REG_TAPS_LOW:     taps_low_r  <= pwdata[TAPS_LOW_W-1:0];
        REG_TAPS_HIGH:    taps_high_r <= pwdata[TAPS_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(width_r);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(height_r);
      REG_TAPS_LOW:     prdata = CFG_DATA_W'(taps_low_r);
      REG_TAPS_HIGH:    prdata = CFG_DATA_W'(taps_high_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow: each stage moves when the one ahead is empty or moving
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic out_free, s3_free, s2_free, s1_free;
  logic s1_mv, accept;

  assign out_free = !out_valid_r || !out_stall;
  assign s3_free  = !s3_v_r || out_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign s1_mv    = s1_v_r && s2_free;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  // ---------------------------------------------------------------------------
  // Stage 0: raster position, line buffer access
  // ---------------------------------------------------------------------------
  logic [AW-1:0]       col_r, col_nxt, col0;
  logic [ROW_W-1:0]    row_r, row_nxt, row0;
  logic [SLOT_W-1:0]   slot_r, slot_nxt, slot0;
  logic [WEW-1:0]      w_eff, w_ext, col_inc;
  logic [HEIGHT_W-1:0] h_eff, row_inc;
  logic                prod0, last0;

  // Clamp the frame size to what the window and the buffers support.
  always_comb begin
    w_ext = WEW'(width_r);
    if (w_ext < WEW'(KERNEL_SIZE)) begin
      w_eff = WEW'(KERNEL_SIZE);
    end else if (w_ext > WEW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (height_r < HEIGHT_W'(KERNEL_SIZE)) begin
      h_eff = HEIGHT_W'(KERNEL_SIZE);
    end else if (height_r > HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  always_comb begin
    // Resync on plane start, then wrap a position left beyond a shrunken frame.
    col0  = in_plane_start ? '0 : col_r;
    row0  = in_plane_start ? '0 : row_r;
    slot0 = in_plane_start ? '0 : slot_r;
    if (WEW'(col0) >= w_eff) begin
      col0 = '0;
    end
    if (HEIGHT_W'(row0) >= h_eff) begin
      row0  = '0;
      slot0 = '0;
    end

    prod0 = (HEIGHT_W'(row0) >= HEIGHT_W'(KERNEL_SIZE - 1)) &&
            (WEW'(col0) >= WEW'(KERNEL_SIZE - 1));
    last0 = (HEIGHT_W'(row0) == h_eff - HEIGHT_W'(1)) &&
            (WEW'(col0) == w_eff - WEW'(1));

    // Advance column, then row at the end of a line.
    col_inc  = WEW'(col0) + WEW'(1);
    row_inc  = HEIGHT_W'(row0) + HEIGHT_W'(1);
    col_nxt  = col_inc[AW-1:0];
    row_nxt  = row0;
    slot_nxt = slot0;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      if (row_inc >= h_eff) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_inc[ROW_W-1:0];
        slot_nxt = (slot0 == SLOT_W'(SLOTS - 1)) ? '0 : slot0 + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  lb_ctrl_t                       lb_ctrl;
  logic [SLOTS-1:0][PIX_W-1:0]    lb_col;

  assign lb_ctrl.en      = accept;
  assign lb_ctrl.wr_slot = slot0;
  assign lb_ctrl.rd_rot  = slot0;

  c2dv_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .SLOTS     (SLOTS)
  ) u_line_buf (
    .clk      (clk),
    .ctrl     (lb_ctrl),
    .addr     (col0),
    .wr_data  (in_pixel),
    .col_data (lb_col)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: window column, tap products
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_prod_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_pixel;
      s1_prod_r <= prod0;
      s1_last_r <= last0;
    end
  end

  logic [SLOTS-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] win_r;
  logic [KERNEL_SIZE-1:0][PIX_W-1:0]            column;
  logic [TAPS_HIGH_W+TAPS_LOW_W-1:0]            all_taps;
  logic signed [PROD_W-1:0]                     prod_nxt [NT];
  logic signed [PROD_W-1:0]                     s2_prod_r [NT];
  logic                                         s2_last_r;

  assign all_taps = {taps_high_r, taps_low_r};

  always_comb begin
    logic [PIX_W-1:0]        p;
    logic signed [PIX_W-1:0] pc;
    logic signed [TAP_W-1:0] tp;
    p  = '0;
    pc = '0;
    tp = '0;
    for (int r = 0; r < SLOTS; r++) begin
      column[r] = lb_col[r];
    end
    column[KERNEL_SIZE-1] = s1_pix_r;
    for (int h = 0; h < KERNEL_SIZE; h++) begin
      for (int w = 0; w < KERNEL_SIZE; w++) begin
        if (w == KERNEL_SIZE - 1) begin
          p = column[h];
        end else begin
          p = win_r[KERNEL_SIZE-2-w][h];
        end
        // Recenter: p - 128 is the byte with its top bit flipped.
        pc = signed'(p ^ 8'h80);
        tp = signed'(all_taps[(h*KERNEL_SIZE+w)*TAP_W +: TAP_W]);
        prod_nxt[h*KERNEL_SIZE+w] = PROD_W'(pc) * PROD_W'(tp);
      end
    end
  end

  // Shift the window as the pixel leaves stage 1, newest column in slot 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_mv) begin
      for (int c = SLOTS - 1; c > 0; c--) begin
        win_r[c] <= win_r[c-1];
      end
      win_r[0] <= column;
    end
  end

  // Drop pixels that complete no window here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r && s1_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_mv) begin
      s2_prod_r <= prod_nxt;
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sum of products
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_nxt, s3_sum_r;
  logic                    s3_last_r;

  always_comb begin
    sum_nxt = '0;
    for (int t = 0; t < NT; t++) begin
      sum_nxt = sum_nxt + SUM_W'(s2_prod_r[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_free) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s3_free) begin
      s3_sum_r  <= sum_nxt;
      s3_last_r <= s2_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide by 2*taps toward zero, saturate
  // ---------------------------------------------------------------------------
  logic                      neg;
  logic [SUM_W-1:0]          mag;
  logic [SUM_W+RECIP_W-1:0]  qprod;
  logic [QMAG_W-1:0]         qmag;
  logic signed [CONV_W-1:0]  conv_nxt, out_conv_r;
  logic                      out_last_r;

  always_comb begin
    neg   = s3_sum_r[SUM_W-1];
    mag   = neg ? SUM_W'(-s3_sum_r) : SUM_W'(s3_sum_r);
    // Reciprocal multiply is exact for every magnitude the sum can reach.
    qprod = (SUM_W+RECIP_W)'(mag) * (SUM_W+RECIP_W)'(RECIP_W'(RECIP));
    qmag  = qprod[SUM_W+RECIP_W-1:DIV_SHIFT];
    if (!neg) begin
      conv_nxt = (qmag > QMAG_W'(CONV_POS_MAX)) ? CONV_W'(CONV_POS_MAX) : CONV_W'(qmag);
    end else if (qmag > QMAG_W'(CONV_NEG_MAX)) begin
      conv_nxt = CONV_W'(-CONV_NEG_MAX);
    end else begin
      conv_nxt = CONV_W'(-signed'({1'b0, qmag}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && out_free) begin
      out_conv_r <= conv_nxt;
      out_last_r <= s3_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_conv_value    = out_conv_r;
  assign out_last_of_plane = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // Intake stops only while stage 1 holds a request.
  a_stall_needs_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("in_stall raised with stage 1 empty");

  // A result held at the output keeps the sum behind it intact.
  a_s3_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && s3_v_r) |=> (s3_v_r && $stable(s3_sum_r)))
    else $error("stage 3 overwritten while output stalled");

  // A plane start puts the next pixel at column one.
  a_plane_resync : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_plane_start) |=> (col_r == AW'(1)))
    else $error("position not resynced on plane start");
`endif

endmodule

// ===== hdl/c2dv_line_buf.sv =====
// Line buffers: one byte memory per earlier row, registered read, rotated column out.
module c2dv_line_buf
  import c2dv_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int SLOTS     = 2
) (
  input  logic                               clk,
  input  lb_ctrl_t                           ctrl,
  input  logic [$clog2(MAX_WIDTH)-1:0]       addr,
  input  logic [PIX_W-1:0]                   wr_data,
  output logic [SLOTS-1:0][PIX_W-1:0]        col_data
);

  logic [PIX_W-1:0]  rd_data [SLOTS];
  logic [SLOT_W-1:0] rot_r;

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_r;

    // Read returns the old entry when the same column is written.
    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        rd_r <= mem[addr];
        if (ctrl.wr_slot == SLOT_W'(g)) begin
          mem[addr] <= wr_data;
        end
      end
    end

    assign rd_data[g] = rd_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      rot_r <= ctrl.rd_rot;
    end
  end

  // Output r is the slot (rot + r) mod SLOTS: oldest row first.
  always_comb begin
    logic [1:0] sel;
    sel = '0;
    for (int r = 0; r < SLOTS; r++) begin
      sel = 2'(rot_r) + 2'(r);
      if (sel >= 2'(SLOTS)) begin
        sel = sel - 2'(SLOTS);
      end
      col_data[r] = rd_data[0];
      for (int g = 0; g < SLOTS; g++) begin
        if (sel == 2'(g)) begin
          col_data[r] = rd_data[g];
        end
      end
    end
  end

endmodule
